FILE: rtl/core/nearest_blob_steering_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the nearest blob steering block
// Concurrent checks that are compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef NEAREST_BLOB_STEERING_TOP_MACROS_SVH
`define NEAREST_BLOB_STEERING_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define NBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nearest blob steering check failed");
`define NBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nearest blob steering check failed");
`else
`define NBS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define NBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/nbs_pkg.sv
// ---------------------------------------------------------------------------
// nbs_pkg
// Shared types and constants of the nearest blob steering block.
// ---------------------------------------------------------------------------
package nbs_pkg;

  localparam int CNT_W      = 8;
  localparam int POS_W      = 14;
  localparam int AREA_W     = 16;
  localparam int CENTER_W   = 10;
  localparam int ERR_W      = 11;
  localparam int GAIN_W     = 14;
  localparam int BASE_W     = 12;
  localparam int LEFT_W     = 17;
  localparam int RIGHT_W    = 18;
  localparam int GAIN_FRAC  = 8;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;

  localparam logic [ERR_W-2:0]    ERR_MAX      = 10'd1023;
  localparam logic [CENTER_W-1:0] CENTER_X_RST = 10'd320;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = 10'd45;

  localparam logic [LEFT_W-1:0]         LEFT_FLOOR = 17'd10;
  localparam logic signed [RIGHT_W-1:0] RIGHT_CEIL = -18'sd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WIDTH   = 3'd0,
    CFG_MIN_AREA     = 3'd1,
    CFG_GATE_DIST_SQ = 3'd2,
    CFG_GAIN_NEAR    = 3'd3,
    CFG_GAIN_FAR     = 3'd4,
    CFG_BASE_SPEED   = 3'd5,
    CFG_ERROR_SPLIT  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [9:0]        half_width;
    logic [AREA_W-1:0] min_area;
    logic [19:0]       gate_dist_sq;
    logic [GAIN_W-1:0] gain_near;
    logic [GAIN_W-1:0] gain_far;
    logic [BASE_W-1:0] base_speed;
    logic [9:0]        error_split;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    half_width:   10'd320,
    min_area:     16'd50,
    gate_dist_sq: 20'd5625,
    gain_near:    14'd256,
    gain_far:     14'd256,
    base_speed:   12'd100,
    error_split:  10'd200
  };

  typedef struct packed {
    logic                    found;
    logic [CNT_W-1:0]        index;
    logic signed [ERR_W-1:0] err;
  } fe_t;

endpackage

FILE: rtl/core/nbs_track.sv
// ---------------------------------------------------------------------------
// nbs_track
// Per-record nearest blob selection and end-of-frame center/error update.
// ---------------------------------------------------------------------------
`include "nearest_blob_steering_top_macros.svh"

module nbs_track
  import nbs_pkg::*;
#(
  parameter int MAX_BLOBS = 255,
  parameter int FRAC_BITS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              go_i,
  input  logic              mode_i,
  input  logic [AREA_W-1:0] area_i,
  input  logic [POS_W-1:0]  cx_i,
  input  logic [POS_W-1:0]  cy_i,
  input  logic              fe_advance_i,
  output logic              fe_free_o,
  output logic              fe_valid_o,
  output fe_t               fe_o
);

  localparam int PW = (CENTER_W + FRAC_BITS > POS_W) ? CENTER_W + FRAC_BITS : POS_W;
  localparam int DW = 2 * PW + 1;

  logic [CENTER_W-1:0]     center_x_r, center_y_r;
  logic [DW-1:0]           best_dist_r;
  logic [POS_W-1:0]        best_x_r, best_y_r;
  logic [CNT_W-1:0]        best_slot_r, blob_count_r;
  logic signed [ERR_W-1:0] held_error_r;
  logic                    fe_valid_r;
  fe_t                     fe_r;

  logic signed [PW:0]      dx, dy, ediff;
  logic [PW-1:0]           mx, my, emag, emag_sh;
  logic [2*PW-1:0]         sqx, sqy;
  logic [DW-1:0]           cand_dist, gate_ext;
  logic [ERR_W-2:0]        esat;
  logic signed [ERR_W-1:0] err_nxt;
  logic [POS_W-1:0]        bx_sh, by_sh;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    cnt_full, take, found;

  always_comb begin
    dx  = $signed(((PW+1)'(center_x_r)) << FRAC_BITS) - $signed((PW+1)'(cx_i));
    dy  = $signed(((PW+1)'(center_y_r)) << FRAC_BITS) - $signed((PW+1)'(cy_i));
    mx  = dx[PW] ? PW'(-dx) : PW'(dx);
    my  = dy[PW] ? PW'(-dy) : PW'(dy);
    sqx = mx * mx;
    sqy = my * my;
    cand_dist = DW'(sqx) + DW'(sqy);
    gate_ext  = DW'(cfg.gate_dist_sq) << (2 * FRAC_BITS);
    cnt_full  = blob_count_r >= CNT_W'(MAX_BLOBS);
    cnt_inc   = blob_count_r + CNT_W'(1);
    take      = !cnt_full && (area_i >= cfg.min_area) &&
                (cand_dist < best_dist_r) && (cand_dist < gate_ext);

    ediff   = $signed(((PW+1)'(cfg.half_width)) << FRAC_BITS) - $signed((PW+1)'(best_x_r));
    emag    = ediff[PW] ? PW'(-ediff) : PW'(ediff);
    emag_sh = emag >> FRAC_BITS;
    esat    = (emag_sh > PW'(ERR_MAX)) ? ERR_MAX : emag_sh[ERR_W-2:0];
    err_nxt = ediff[PW] ? -$signed({1'b0, esat}) : $signed({1'b0, esat});
    bx_sh   = best_x_r >> FRAC_BITS;
    by_sh   = best_y_r >> FRAC_BITS;
    found   = best_slot_r != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= CENTER_X_RST;
      center_y_r   <= CENTER_Y_RST;
      best_dist_r  <= '1;
      best_slot_r  <= '0;
      blob_count_r <= '0;
      held_error_r <= '0;
      fe_valid_r   <= 1'b0;
    end else begin
      if (go_i && mode_i) begin
        fe_valid_r <= 1'b1;
      end else if (fe_advance_i) begin
        fe_valid_r <= 1'b0;
      end
      if (go_i) begin
        if (!mode_i) begin
          if (!cnt_full) begin
            blob_count_r <= cnt_inc;
          end
          if (take) begin
            best_dist_r <= cand_dist;
            best_slot_r <= cnt_inc;
          end
        end else begin
          if (found) begin
            held_error_r <= err_nxt;
            center_x_r   <= bx_sh[CENTER_W-1:0];
            center_y_r   <= by_sh[CENTER_W-1:0];
          end
          best_dist_r  <= '1;
          best_slot_r  <= '0;
          blob_count_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_i && !mode_i && take) begin
      best_x_r <= cx_i;
      best_y_r <= cy_i;
    end
    if (go_i && mode_i) begin
      fe_r.found <= found;
      fe_r.index <= best_slot_r;
      fe_r.err   <= found ? err_nxt : held_error_r;
    end
  end

  assign fe_free_o  = !fe_valid_r || fe_advance_i;
  assign fe_valid_o = fe_valid_r;
  assign fe_o       = fe_r;

  `NBS_ASSERT_NEXT(fe_clears_run, clk, rst_n, go_i && mode_i,
                   (blob_count_r == '0) && (best_slot_r == '0))
  `NBS_ASSERT_SAME(slot_within_count, clk, rst_n, 1'b1, best_slot_r <= blob_count_r)
  `NBS_ASSERT_SAME(count_bounded, clk, rst_n, 1'b1, blob_count_r <= CNT_W'(MAX_BLOBS))

endmodule

FILE: rtl/core/nbs_speed.sv
// ---------------------------------------------------------------------------
// nbs_speed
// Gain selection, steering product and wheel speed result register.
// ---------------------------------------------------------------------------
module nbs_speed
  import nbs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      fe_valid_i,
  input  fe_t                       fe_i,
  output logic                      fe_advance_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic                      found_o,
  output logic [CNT_W-1:0]          index_o,
  output logic signed [ERR_W-1:0]   err_o,
  output logic [LEFT_W-1:0]         left_o,
  output logic signed [RIGHT_W-1:0] right_o
);

  localparam int PRODW = GAIN_W + ERR_W + 1;
  localparam int SUMW  = PRODW + 1;

  logic                    p_valid_r, out_valid_r;
  fe_t                     p_fe_r;
  logic signed [PRODW-1:0] p_prod_r;
  logic                    out_found_r;
  logic [CNT_W-1:0]        out_index_r;
  logic signed [ERR_W-1:0] out_err_r;
  logic [LEFT_W-1:0]       out_left_r;
  logic signed [RIGHT_W-1:0] out_right_r;

  logic                    out_free, p_free;
  logic [ERR_W-1:0]        err_mag;
  logic [GAIN_W-1:0]       gain;
  logic signed [PRODW-1:0] prod_nxt;
  logic signed [SUMW-1:0]  base_q, prod_x, lsum, rsum, ltr, rtr;
  logic [LEFT_W-1:0]       left_nxt;
  logic signed [RIGHT_W-1:0] right_nxt;

  assign out_free     = !out_valid_r || out_ready_i;
  assign p_free       = !p_valid_r || out_free;
  assign fe_advance_o = p_free;

  always_comb begin
    err_mag  = fe_i.err[ERR_W-1] ? ERR_W'(-fe_i.err) : ERR_W'(fe_i.err);
    gain     = (err_mag >= ERR_W'(cfg.error_split)) ? cfg.gain_far : cfg.gain_near;
    prod_nxt = $signed({1'b0, gain}) * fe_i.err;

    base_q = $signed(SUMW'(cfg.base_speed) << GAIN_FRAC);
    prod_x = SUMW'(p_prod_r);
    lsum   = base_q - prod_x;
    rsum   = -(base_q + prod_x);
    ltr    = lsum[SUMW-1] ? (lsum + SUMW'(255)) >>> GAIN_FRAC : lsum >>> GAIN_FRAC;
    rtr    = rsum[SUMW-1] ? (rsum + SUMW'(255)) >>> GAIN_FRAC : rsum >>> GAIN_FRAC;
    left_nxt  = ltr[SUMW-1] ? LEFT_FLOOR : ltr[LEFT_W-1:0];
    right_nxt = (!rtr[SUMW-1] && (rtr != '0)) ? RIGHT_CEIL : rtr[RIGHT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (p_free) begin
        p_valid_r <= fe_valid_i;
      end
      if (out_free) begin
        out_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_free && fe_valid_i) begin
      p_fe_r   <= fe_i;
      p_prod_r <= prod_nxt;
    end
    if (out_free && p_valid_r) begin
      out_found_r <= p_fe_r.found;
      out_index_r <= p_fe_r.index;
      out_err_r   <= p_fe_r.err;
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
    end
  end

  assign out_valid_o = out_valid_r;
  assign found_o     = out_found_r;
  assign index_o     = out_index_r;
  assign err_o       = out_err_r;
  assign left_o      = out_left_r;
  assign right_o     = out_right_r;

endmodule

FILE: rtl/core/nearest_blob_steering_top.sv
// ---------------------------------------------------------------------------
// nearest_blob_steering_top
// Picks the blob nearest the tracked center in each frame and steers to it.
// ---------------------------------------------------------------------------
// The block takes one transaction per clock cycle. A blob record is folded
// into the running nearest-blob search in the cycle after it is accepted and
// never produces a result. An end-of-frame transaction passes in turn through
// the input register, selection stage, gain product stage and result register,
// producing one result. Input is held back only while an end-of-frame
// transaction waits and all three result stages are full, the result not taken.
`include "nearest_blob_steering_top_macros.svh"

module nearest_blob_steering_top
  import nbs_pkg::*;
#(
  parameter int MAX_BLOBS = 255,
  parameter int FRAC_BITS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] blob_area, [29:16] centroid_x, [43:30] centroid_y, [47:44] zero
  input  logic [47:0]           in_tdata,
  // [0] mode
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] target_index, [18:8] steer_error, [35:19] left_speed,
  // [53:36] right_speed, [55:54] zero
  output logic [55:0]           out_tdata,
  // [0] found
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg_r;
  logic              a_valid_r, a_mode_r;
  logic [AREA_W-1:0] a_area_r;
  logic [POS_W-1:0]  a_cx_r, a_cy_r;

  logic                      a_go, fe_free, fe_valid, fe_advance;
  fe_t                       fe;
  logic                      found;
  logic [CNT_W-1:0]          index;
  logic signed [ERR_W-1:0]   err;
  logic [LEFT_W-1:0]         left_speed;
  logic signed [RIGHT_W-1:0] right_speed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_WIDTH:   cfg_r.half_width   <= cfg_data[9:0];
        CFG_MIN_AREA:     cfg_r.min_area     <= cfg_data[AREA_W-1:0];
        CFG_GATE_DIST_SQ: cfg_r.gate_dist_sq <= cfg_data[19:0];
        CFG_GAIN_NEAR:    cfg_r.gain_near    <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_FAR:     cfg_r.gain_far     <= cfg_data[GAIN_W-1:0];
        CFG_BASE_SPEED:   cfg_r.base_speed   <= cfg_data[BASE_W-1:0];
        CFG_ERROR_SPLIT:  cfg_r.error_split  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign a_go      = a_valid_r && (!a_mode_r || fe_free);
  assign in_tready = !a_valid_r || a_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_mode_r <= in_tuser;
      a_area_r <= in_tdata[15:0];
      a_cx_r   <= in_tdata[29:16];
      a_cy_r   <= in_tdata[43:30];
    end
  end

  nbs_track #(
    .MAX_BLOBS (MAX_BLOBS),
    .FRAC_BITS (FRAC_BITS)
  ) u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .go_i         (a_go),
    .mode_i       (a_mode_r),
    .area_i       (a_area_r),
    .cx_i         (a_cx_r),
    .cy_i         (a_cy_r),
    .fe_advance_i (fe_advance),
    .fe_free_o    (fe_free),
    .fe_valid_o   (fe_valid),
    .fe_o         (fe)
  );

  nbs_speed u_speed (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .fe_valid_i   (fe_valid),
    .fe_i         (fe),
    .fe_advance_o (fe_advance),
    .out_ready_i  (out_tready),
    .out_valid_o  (out_tvalid),
    .found_o      (found),
    .index_o      (index),
    .err_o        (err),
    .left_o       (left_speed),
    .right_o      (right_speed)
  );

  assign out_tdata = {2'b00, right_speed, left_speed, err, index};
  assign out_tuser = found;

  `NBS_ASSERT_SAME(stall_only_when_full, clk, rst_n, !in_tready, a_valid_r && a_mode_r && out_tvalid && !out_tready)
  `NBS_ASSERT_SAME(found_matches_index, clk, rst_n, out_tvalid, out_tuser == (out_tdata[7:0] != 8'd0))
  `NBS_ASSERT_SAME(right_not_positive, clk, rst_n, out_tvalid, out_tdata[53] || (out_tdata[53:36] == 18'd0))

endmodule

FILE: tb/tb_nearest_blob_steering_top.sv
// ---------------------------------------------------------------------------
// tb_nearest_blob_steering_top
// Streams blob records and frame ends into the nearest blob steering block
// and checks every frame result against a cycle-free model of the target
// selection, the steering error and the wheel speeds. Directed frames cover
// the field extremes, the distance gate, ties, empty frames and blob
// overflow. Random frames then run under several register settings, with
// random idling on both streams and one long output stall.
// ---------------------------------------------------------------------------
module tb_nearest_blob_steering_top
  import nbs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BLOBS = 255;
  localparam int FRAC_BITS = 4;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_STALL = 300;
  localparam logic MODE_BLOB = 1'b0;
  localparam logic MODE_EOF = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
  localparam longint DIST_NONE = 64'h3FFF_FFFF;

  typedef struct {
    logic       found;
    logic [7:0] index;
    longint     err;
    longint     left;
    longint     right;
  } steer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic calm = 1'b0;
  int stall_asks = 0;
  int asks_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int bad_count = 0;
  int blob_items = 0;
  int frame_ends = 0;
  int found_frames = 0;
  int phases_run = 0;

  cfg_t shadow;
  logic [CENTER_W-1:0] trk_cx, trk_cy;
  longint best_d;
  logic [POS_W-1:0] best_px, best_py;
  int best_slot, blob_cnt, held_err;
  steer_result_t pending_steer[$];

  nearest_blob_steering_top #(
    .MAX_BLOBS(MAX_BLOBS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint shift_trunc(longint v, int s);
    return (v < 0) ? -((-v) >> s) : (v >> s);
  endfunction

  function automatic longint sq_offset(logic [CENTER_W-1:0] c, logic [POS_W-1:0] p);
    longint d;
    d = (longint'(c) <<< FRAC_BITS) - longint'(p);
    return d * d;
  endfunction

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  function automatic logic [POS_W-1:0] near_pos(logic [CENTER_W-1:0] c, int span);
    return clip(int'(c) * 16 + int'($urandom_range(2 * span)) - span, 16383);
  endfunction

  function automatic void reset_tracker();
    shadow = CFG_RST;
    trk_cx = CENTER_X_RST;
    trk_cy = CENTER_Y_RST;
    best_d = DIST_NONE;
    best_px = '0;
    best_py = '0;
    best_slot = 0;
    blob_cnt = 0;
    held_err = 0;
  endfunction

  function automatic void fold_blob(logic [AREA_W-1:0] area, logic [POS_W-1:0] cx,
                                    logic [POS_W-1:0] cy);
    longint d;
    if (blob_cnt >= MAX_BLOBS) return;
    blob_cnt++;
    if (area < shadow.min_area) return;
    d = sq_offset(trk_cx, cx) + sq_offset(trk_cy, cy);
    if (d < best_d && d < (longint'(shadow.gate_dist_sq) <<< (2 * FRAC_BITS))) begin
      best_d = d;
      best_px = cx;
      best_py = cy;
      best_slot = blob_cnt;
    end
  endfunction

  function automatic void close_frame();
    steer_result_t r;
    longint diff, e, base_q, prod, lv, rv;
    int mag;
    logic [GAIN_W-1:0] gain;
    r.found = (best_slot != 0);
    if (r.found) begin
      diff = (longint'(shadow.half_width) <<< FRAC_BITS) - longint'(best_px);
      e = shift_trunc(diff, FRAC_BITS);
      if (e > longint'(ERR_MAX)) e = longint'(ERR_MAX);
      if (e < -longint'(ERR_MAX)) e = -longint'(ERR_MAX);
      held_err = int'(e);
      trk_cx = best_px >> FRAC_BITS;
      trk_cy = best_py >> FRAC_BITS;
      found_frames++;
    end
    mag = (held_err < 0) ? -held_err : held_err;
    gain = (mag >= int'(shadow.error_split)) ? shadow.gain_far : shadow.gain_near;
    base_q = longint'(shadow.base_speed) <<< GAIN_FRAC;
    prod = longint'(gain) * longint'(held_err);
    lv = shift_trunc(base_q - prod, GAIN_FRAC);
    if (lv < 0) lv = longint'(LEFT_FLOOR);
    rv = shift_trunc(-(base_q + prod), GAIN_FRAC);
    if (rv > 0) rv = longint'(RIGHT_CEIL);
    r.index = best_slot[7:0];
    r.err = held_err;
    r.left = lv;
    r.right = rv;
    pending_steer.push_back(r);
    best_d = DIST_NONE;
    best_slot = 0;
    blob_cnt = 0;
    frame_ends++;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_count++;
    end
  endfunction

  task automatic send_item(input logic mode, input logic [AREA_W-1:0] area,
                           input logic [POS_W-1:0] cx, input logic [POS_W-1:0] cy);
    if (!calm && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {4'b0000, cy, cx, area};
    do @(posedge clk); while (!in_tready);
    if (mode == MODE_EOF) begin
      close_frame();
    end else begin
      fold_blob(area, cx, cy);
      blob_items++;
    end
  endtask

  task automatic send_frame_end();
    send_item(MODE_EOF, AREA_W'($urandom), POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic send_frame(output int n);
    int nb, kind, span;
    logic [AREA_W-1:0] a;
    logic [POS_W-1:0] x, y;
    nb = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    n = nb + 1;
    for (int i = 0; i < nb; i++) begin
      kind = $urandom_range(9);
      // A repeat of the previous record makes a tie that the earlier blob wins.
      if (!(kind == 9 && i > 0)) begin
        if (kind < 2) begin
          a = $urandom;
          x = $urandom;
          y = $urandom;
        end else begin
          case ($urandom_range(3))
            0: span = 16;
            1: span = 256;
            2: span = 1200;
            default: span = 6000;
          endcase
          x = near_pos(trk_cx, span);
          y = near_pos(trk_cy, span);
          a = $urandom_range(1) ? AREA_W'($urandom)
                                : clip(int'(shadow.min_area) + int'($urandom_range(4)) - 2,
                                       65535);
        end
      end
      send_item(MODE_BLOB, a, x, y);
    end
    send_frame_end();
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_steer.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                         input int width);
    logic [CFG_DATA_W-1:0] word;
    // Bits above the register width are junk and must be dropped by the block.
    word = CFG_DATA_W'(value | ($urandom << width));
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    @(posedge clk);
    case (idx)
      CFG_HALF_WIDTH: shadow.half_width = word[9:0];
      CFG_MIN_AREA: shadow.min_area = word[AREA_W-1:0];
      CFG_GATE_DIST_SQ: shadow.gate_dist_sq = word[19:0];
      CFG_GAIN_NEAR: shadow.gain_near = word[GAIN_W-1:0];
      CFG_GAIN_FAR: shadow.gain_far = word[GAIN_W-1:0];
      CFG_BASE_SPEED: shadow.base_speed = word[BASE_W-1:0];
      CFG_ERROR_SPLIT: shadow.error_split = word[9:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input cfg_t s);
    put_reg(CFG_HALF_WIDTH, s.half_width, 10);
    put_reg(CFG_MIN_AREA, s.min_area, AREA_W);
    put_reg(CFG_GATE_DIST_SQ, s.gate_dist_sq, 20);
    put_reg(CFG_GAIN_NEAR, s.gain_near, GAIN_W);
    put_reg(CFG_GAIN_FAR, s.gain_far, GAIN_W);
    put_reg(CFG_BASE_SPEED, s.base_speed, BASE_W);
    put_reg(CFG_ERROR_SPLIT, s.error_split, 10);
    put_reg(CFG_NONE, $urandom, CFG_DATA_W);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_frames();
    int x0, y0;
    x0 = int'(trk_cx) * 16;
    y0 = int'(trk_cy) * 16;
    // Small blob at the center and a huge blob far away: nothing is chosen.
    send_item(MODE_BLOB, 16'h0000, x0, y0);
    send_item(MODE_BLOB, 16'hFFFF, 14'h3FFF, 14'h3FFF);
    send_frame_end();
    // Area just under and at the minimum, then a tie at the same spot.
    send_item(MODE_BLOB, 16'd49, x0, y0);
    send_item(MODE_BLOB, 16'd50, x0, y0);
    send_item(MODE_BLOB, 16'd50, x0, y0);
    send_frame_end();
    // A blob exactly on the gate radius is rejected, one pixel inside is kept.
    send_item(MODE_BLOB, 16'd500, x0 + 75 * 16, y0);
    send_item(MODE_BLOB, 16'd500, x0 + 74 * 16, y0);
    send_frame_end();
    send_frame_end();
    x0 = int'(trk_cx) * 16;
    y0 = int'(trk_cy) * 16;
    // Fractional centroid, so the error is truncated toward zero.
    send_item(MODE_BLOB, 16'hFFFF, 14'h0000, 14'h0000);
    send_item(MODE_BLOB, 16'd60, x0 + 3, y0 - 5);
    send_frame_end();
    drain();
  endtask

  task automatic test_steering_limits();
    cfg_t s;
    s = CFG_RST;
    s.half_width = '1;
    s.min_area = '0;
    s.gate_dist_sq = '1;
    s.gain_near = '0;
    s.gain_far = '1;
    s.base_speed = '0;
    s.error_split = '1;
    write_settings(s);
    send_item(MODE_BLOB, 16'h0000, 14'h0000, int'(trk_cy) * 16);
    send_frame_end();
    send_item(MODE_BLOB, 16'd7, (1023 - 5) * 16, int'(trk_cy) * 16);
    send_frame_end();
    drain();
    s.half_width = '0;
    s.min_area = '1;
    s.gain_near = '1;
    s.gain_far = '1;
    s.base_speed = '1;
    s.error_split = '0;
    write_settings(s);
    send_item(MODE_BLOB, 16'hFFFF, 14'h3FFF, int'(trk_cy) * 16);
    send_frame_end();
    send_frame_end();
    send_item(MODE_BLOB, 16'hFFFE, int'(trk_cx) * 16, int'(trk_cy) * 16);
    send_frame_end();
    drain();
    write_settings(CFG_RST);
  endtask

  task automatic test_blob_overflow();
    int x0, y0;
    x0 = int'(trk_cx) * 16;
    y0 = int'(trk_cy) * 16;
    for (int i = 1; i < MAX_BLOBS; i++) send_item(MODE_BLOB, 16'd100, x0 - 640, y0);
    send_item(MODE_BLOB, 16'd100, x0 - 480, y0);
    // Records past the per-frame limit would win, but must be ignored.
    repeat (5) send_item(MODE_BLOB, 16'd100, x0, y0);
    send_frame_end();
    send_item(MODE_BLOB, 16'd100, int'(trk_cx) * 16, int'(trk_cy) * 16);
    send_frame_end();
    drain();
  endtask

  task automatic test_output_stall();
    int n;
    stall_asks <= stall_asks + 1;
    calm <= 1'b1;
    repeat (12) send_frame(n);
    calm <= 1'b0;
    drain();
  endtask

  task automatic test_random_settings();
    cfg_t s;
    int sent, n;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: s = CFG_RST;
        1: s = '0;
        2: s = '1;
        default: s = cfg_t'({$urandom, $urandom, $urandom});
      endcase
      calm <= (p == 3);
      write_settings(s);
      sent = 0;
      while (sent < 140) begin
        send_frame(n);
        sent += n;
      end
      drain();
      phases_run++;
    end
    calm <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_asks != asks_seen) begin
      asks_seen <= stall_asks;
      hold_left <= LONG_STALL;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin : result_check
    steer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_steer.size() == 0) begin
        $error("result transaction with no frame end pending");
        bad_count++;
      end else begin
        want = pending_steer.pop_front();
        check_field("found", want.found, out_tuser);
        check_field("target_index", want.index, out_tdata[7:0]);
        check_field("steer_error", want.err, longint'(signed'(out_tdata[18:8])));
        check_field("left_speed", want.left, out_tdata[35:19]);
        check_field("right_speed", want.right, longint'(signed'(out_tdata[53:36])));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_steer.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    reset_tracker();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_steering_limits();
    test_blob_overflow();
    test_output_stall();
    test_random_settings();
    drain();
    $display("%0d blob records and %0d frame ends checked, %0d frames with a target",
             blob_items, frame_ends, found_frames);
    $display("%0d random register phases plus gate, tie, overflow and stall cases",
             phases_run);
    if (bad_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
